// ===== hdl/trcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trcc_pkg
// Shared types and constants of the track road connectivity check.
// ----------------------------------------------------------------------------
package trcc_pkg;

  localparam int unsigned MAX_TRACKS = 64;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned DIST_W     = 24;
  localparam int unsigned STAT_W     = 32;

  // 1000 mm with 8 fraction bits
  localparam logic [DIST_W-1:0] NEAREST_CAP = 24'd256000;

  typedef enum logic [1:0] {
    ACT_BEGIN    = 2'd0,
    ACT_PAIR     = 2'd1,
    ACT_EVALUATE = 2'd2,
    ACT_NONE     = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    VERDICT_TRIVIAL      = 2'd0,
    VERDICT_CONNECTED    = 2'd1,
    VERDICT_ISOLATED     = 2'd2,
    VERDICT_DISCONNECTED = 2'd3
  } verdict_e;

  // one entry per track: nearest distance and adjacency row
  typedef struct packed {
    logic [DIST_W-1:0]     nearest;
    logic [MAX_TRACKS-1:0] row;
  } entry_t;

  typedef struct packed {
    logic             clear;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
  } store_req_t;

endpackage

// ===== hdl/trcc_track_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trcc_track_store
// Per-track memory (nearest distance and adjacency row) with one write and
// one registered read port. Valid bits make a cleared entry read as the cap
// with no links, so an event begin clears every entry together.
// ----------------------------------------------------------------------------
module trcc_track_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  trcc_pkg::store_req_t req_i,
  output trcc_pkg::entry_t    rd_data_o
);

  trcc_pkg::entry_t mem [trcc_pkg::MAX_TRACKS];
  trcc_pkg::entry_t rd_q;
  logic [trcc_pkg::MAX_TRACKS-1:0] valid_q;
  logic rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q <= mem[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.clear) begin
        valid_q <= '0;
      end else if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[req_i.rd_addr];
      end
    end
  end

  always_comb begin
    if (rd_valid_q) begin
      rd_data_o = rd_q;
    end else begin
      rd_data_o.nearest = trcc_pkg::NEAREST_CAP;
      rd_data_o.row     = '0;
    end
  end

endmodule

// ===== hdl/track_road_connectivity_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// track_road_connectivity_check
// Per event: begin with a track count, feed pair distances, evaluate to get
// a verdict. Track state sits in one memory, updated read-modify-write.
// ----------------------------------------------------------------------------
// Begin clears the track store. Pair steps: read a; write a, read b; write b.
// Evaluate of 0 or 1 tracks: result in the cycle after the transfer.
// Evaluate of n >= 2 tracks: P reach passes over the track memory, each
// reading one row per cycle, then the result is registered; 1 <= P <= n.
// The result strobe done_o lasts one cycle; the receiver cannot stall.
// Reset clears control state, counters and the track store valid bits.
module track_road_connectivity_check (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [1:0]                   action_i,
  input  logic [trcc_pkg::CNT_W-1:0]   track_count_i,
  input  logic [trcc_pkg::IDX_W-1:0]   first_track_i,
  input  logic [trcc_pkg::IDX_W-1:0]   second_track_i,
  input  logic [trcc_pkg::DIST_W-1:0]  pair_distance_i,
  input  logic                         road_width_we_i,
  input  logic [trcc_pkg::DIST_W-1:0]  road_width_i,
  output logic                         done_o,
  output logic [1:0]                   verdict_o,
  output logic                         passed_o,
  output logic [trcc_pkg::STAT_W-1:0]  events_seen_o,
  output logic [trcc_pkg::STAT_W-1:0]  events_passed_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_PAIR_B = 2'd1;
  localparam logic [1:0] ST_PAIR_W = 2'd2;
  localparam logic [1:0] ST_EVAL   = 2'd3;

  localparam int unsigned NT = trcc_pkg::MAX_TRACKS;

  logic [1:0] state_q, state_d;
  logic [trcc_pkg::DIST_W-1:0] road_width_q;
  logic [trcc_pkg::CNT_W-1:0]  tracks_q, tracks_d;

  logic [trcc_pkg::IDX_W-1:0]  pair_a_q, pair_a_d, pair_b_q, pair_b_d;
  logic [trcc_pkg::DIST_W-1:0] pair_d_q, pair_d_d;
  logic                        link_q, link_d;

  logic [NT-1:0]              reached_q, reached_d;
  logic [trcc_pkg::IDX_W-1:0] iss_idx_q, iss_idx_d;
  logic                       issuing_q, issuing_d;
  logic                       rsp_valid_q, rsp_valid_d;
  logic [trcc_pkg::IDX_W-1:0] rsp_idx_q, rsp_idx_d;
  logic                       rsp_last_q, rsp_last_d;
  logic                       first_pass_q, first_pass_d;
  logic                       grew_q, grew_d;
  logic                       isolated_q, isolated_d;

  logic                        done_q, done_d;
  logic [1:0]                  verdict_q, verdict_d;
  logic                        passed_q, passed_d;
  logic [trcc_pkg::STAT_W-1:0] seen_q, seen_d, pass_cnt_q, pass_cnt_d;

  trcc_pkg::store_req_t req;
  trcc_pkg::entry_t     rd_data;

  logic                    accept;
  logic                    pair_ok;
  logic                    iss_last;
  logic                    isolated_now, grew_now, all_reached;
  logic [NT-1:0]           reached_now;
  logic [NT:0]             low_mask;
  logic                    finish;
  logic [1:0]              finish_verdict;

  function automatic logic [trcc_pkg::STAT_W-1:0] STAT_ONE(input logic b);
    STAT_ONE = {{(trcc_pkg::STAT_W-1){1'b0}}, b};
  endfunction

  assign accept   = start_i && (state_q == ST_IDLE);
  assign busy_o   = (state_q != ST_IDLE);
  assign pair_ok  = (first_track_i != second_track_i)
                    && ({1'b0, first_track_i} < tracks_q)
                    && ({1'b0, second_track_i} < tracks_q);
  assign iss_last = ({1'b0, iss_idx_q} == (tracks_q - 7'd1));
  assign low_mask = ((NT+1)'(1) << tracks_q) - (NT+1)'(1);

  trcc_track_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req),
    .rd_data_o(rd_data)
  );

  // reach update of the row returned this cycle
  always_comb begin
    isolated_now = isolated_q;
    grew_now     = grew_q;
    reached_now  = reached_q;
    if (rsp_valid_q) begin
      if (first_pass_q && (rd_data.nearest > road_width_q)) begin
        isolated_now = 1'b1;
      end
      if (reached_q[rsp_idx_q] && ((rd_data.row & ~reached_q) != '0)) begin
        reached_now = reached_q | rd_data.row;
        grew_now    = 1'b1;
      end
    end
  end

  assign all_reached = &(reached_now | ~low_mask[NT-1:0]);

  always_comb begin
    state_d      = state_q;
    tracks_d     = tracks_q;
    pair_a_d     = pair_a_q;
    pair_b_d     = pair_b_q;
    pair_d_d     = pair_d_q;
    link_d       = link_q;
    reached_d    = reached_q;
    iss_idx_d    = iss_idx_q;
    issuing_d    = issuing_q;
    rsp_valid_d  = 1'b0;
    rsp_idx_d    = iss_idx_q;
    rsp_last_d   = 1'b0;
    first_pass_d = first_pass_q;
    grew_d       = grew_q;
    isolated_d   = isolated_q;
    finish         = 1'b0;
    finish_verdict = trcc_pkg::VERDICT_TRIVIAL;

    req.clear   = 1'b0;
    req.rd_en   = 1'b0;
    req.rd_addr = first_track_i;
    req.wr_en   = 1'b0;
    req.wr_addr = pair_a_q;
    req.wr_data = rd_data;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (action_i)
            trcc_pkg::ACT_BEGIN: begin
              tracks_d  = (track_count_i > trcc_pkg::CNT_W'(NT))
                          ? trcc_pkg::CNT_W'(NT) : track_count_i;
              req.clear = 1'b1;
            end
            trcc_pkg::ACT_PAIR: begin
              if (pair_ok) begin
                req.rd_en = 1'b1;
                pair_a_d  = first_track_i;
                pair_b_d  = second_track_i;
                pair_d_d  = pair_distance_i;
                link_d    = (pair_distance_i < road_width_q);
                state_d   = ST_PAIR_B;
              end
            end
            trcc_pkg::ACT_EVALUATE: begin
              if (tracks_q <= 7'd1) begin
                finish         = 1'b1;
                finish_verdict = trcc_pkg::VERDICT_TRIVIAL;
              end else begin
                reached_d    = NT'(1);
                iss_idx_d    = '0;
                issuing_d    = 1'b1;
                first_pass_d = 1'b1;
                grew_d       = 1'b0;
                isolated_d   = 1'b0;
                state_d      = ST_EVAL;
              end
            end
            default: ;
          endcase
        end
      end
      ST_PAIR_B: begin
        // entry a is back: update it, fetch entry b
        req.wr_en           = 1'b1;
        req.wr_addr         = pair_a_q;
        req.wr_data.nearest = (pair_d_q < rd_data.nearest) ? pair_d_q : rd_data.nearest;
        req.wr_data.row     = rd_data.row | (NT'(link_q) << pair_b_q);
        req.rd_en           = 1'b1;
        req.rd_addr         = pair_b_q;
        state_d             = ST_PAIR_W;
      end
      ST_PAIR_W: begin
        req.wr_en           = 1'b1;
        req.wr_addr         = pair_b_q;
        req.wr_data.nearest = (pair_d_q < rd_data.nearest) ? pair_d_q : rd_data.nearest;
        req.wr_data.row     = rd_data.row | (NT'(link_q) << pair_a_q);
        state_d             = ST_IDLE;
      end
      ST_EVAL: begin
        req.rd_en   = issuing_q;
        req.rd_addr = iss_idx_q;
        if (issuing_q) begin
          rsp_valid_d = 1'b1;
          rsp_last_d  = iss_last;
          if (iss_last) begin
            issuing_d = 1'b0;
          end else begin
            iss_idx_d = iss_idx_q + 6'd1;
          end
        end
        reached_d  = reached_now;
        grew_d     = grew_now;
        isolated_d = isolated_now;
        if (rsp_valid_q && rsp_last_q) begin
          if (isolated_now) begin
            finish         = 1'b1;
            finish_verdict = trcc_pkg::VERDICT_ISOLATED;
          end else if (tracks_q == 7'd2) begin
            finish         = 1'b1;
            finish_verdict = trcc_pkg::VERDICT_CONNECTED;
          end else if (grew_now) begin
            // closure still growing: another pass
            iss_idx_d    = '0;
            issuing_d    = 1'b1;
            first_pass_d = 1'b0;
            grew_d       = 1'b0;
          end else begin
            finish         = 1'b1;
            finish_verdict = all_reached ? trcc_pkg::VERDICT_CONNECTED
                                         : trcc_pkg::VERDICT_DISCONNECTED;
          end
          if (finish) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    done_d     = finish;
    verdict_d  = verdict_q;
    passed_d   = passed_q;
    seen_d     = seen_q;
    pass_cnt_d = pass_cnt_q;
    if (finish) begin
      verdict_d = finish_verdict;
      passed_d  = (finish_verdict == trcc_pkg::VERDICT_TRIVIAL)
                  || (finish_verdict == trcc_pkg::VERDICT_CONNECTED);
      seen_d    = seen_q + 32'd1;
      pass_cnt_d = pass_cnt_q + STAT_ONE(passed_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      road_width_q <= '0;
      tracks_q     <= '0;
      issuing_q    <= 1'b0;
      rsp_valid_q  <= 1'b0;
      rsp_last_q   <= 1'b0;
      first_pass_q <= 1'b0;
      grew_q       <= 1'b0;
      isolated_q   <= 1'b0;
      done_q       <= 1'b0;
      seen_q       <= '0;
      pass_cnt_q   <= '0;
    end else begin
      state_q      <= state_d;
      if (road_width_we_i) begin
        road_width_q <= road_width_i;
      end
      tracks_q     <= tracks_d;
      issuing_q    <= issuing_d;
      rsp_valid_q  <= rsp_valid_d;
      rsp_last_q   <= rsp_last_d;
      first_pass_q <= first_pass_d;
      grew_q       <= grew_d;
      isolated_q   <= isolated_d;
      done_q       <= done_d;
      seen_q       <= seen_d;
      pass_cnt_q   <= pass_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pair_a_q  <= pair_a_d;
    pair_b_q  <= pair_b_d;
    pair_d_q  <= pair_d_d;
    link_q    <= link_d;
    reached_q <= reached_d;
    iss_idx_q <= iss_idx_d;
    rsp_idx_q <= rsp_idx_d;
    verdict_q <= verdict_d;
    passed_q  <= passed_d;
  end

  assign done_o          = done_q;
  assign verdict_o       = verdict_q;
  assign passed_o        = passed_q;
  assign events_seen_o   = seen_q;
  assign events_passed_o = pass_cnt_q;

endmodule
